### rtl/qtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared constants, register codes and the coefficient weight table of the
// quintic trajectory generator.
// ----------------------------------------------------------------------------
package qtg_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int COEFF_FRAC_BITS = 32;
  localparam int DATA_W          = 32;
  localparam int COEF_W          = 64;
  localparam int NUM_COEF        = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int ACC_W           = 72;
  localparam int DIV_W           = COEF_W + FRAC_BITS;
  localparam int COEFF_SHIFT     = 2 * FRAC_BITS + 1 - COEFF_FRAC_BITS;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME     = 3'd0,
    REG_END_TIME       = 3'd1,
    REG_START_POSITION = 3'd2,
    REG_END_POSITION   = 3'd3,
    REG_START_VELOCITY = 3'd4,
    REG_END_VELOCITY   = 3'd5,
    REG_START_ACCEL    = 3'd6,
    REG_END_ACCEL      = 3'd7
  } cfg_reg_t;

  // phase codes
  localparam logic [1:0] PHASE_BEFORE = 2'd0;
  localparam logic [1:0] PHASE_WINDOW = 2'd1;
  localparam logic [1:0] PHASE_AFTER  = 2'd2;

  // weights of the doubled coefficients over {2p0, h, v0T, vfT, a0T^2, afT^2}
  localparam logic signed [5:0] WEIGHT [NUM_COEF][NUM_COEF] = '{
    '{ 6'sd1,   6'sd0,   6'sd0,   6'sd0,   6'sd0,  6'sd0 },
    '{ 6'sd0,   6'sd0,   6'sd2,   6'sd0,   6'sd0,  6'sd0 },
    '{ 6'sd0,   6'sd0,   6'sd0,   6'sd0,   6'sd1,  6'sd0 },
    '{ 6'sd0,   6'sd20, -6'sd12, -6'sd8,  -6'sd3,  6'sd1 },
    '{ 6'sd0,  -6'sd30,  6'sd16,  6'sd14,  6'sd3, -6'sd2 },
    '{ 6'sd0,   6'sd12, -6'sd6,  -6'sd6,  -6'sd1,  6'sd1 }
  };

endpackage

### rtl/qtg_query_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_query_if
// Query channel: one time stamp per transaction.
// ----------------------------------------------------------------------------
interface qtg_query_if;
  import qtg_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] query_time;

  modport source (output valid, output query_time, input ready);
  modport sink   (input valid, input query_time, output ready);
endinterface

### rtl/qtg_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_result_if
// Result channel: position, velocity, acceleration and status per transaction.
// ----------------------------------------------------------------------------
interface qtg_result_if;
  import qtg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] acceleration;
  logic [1:0]               phase;
  logic                     bad_duration;

  modport source (output valid, output position, output velocity, output acceleration,
                  output phase, output bad_duration, input ready);
  modport sink   (input valid, input position, input velocity, input acceleration,
                  input phase, input bad_duration, output ready);
endinterface

### rtl/quintic_trajectory_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_core
// Quintic point-to-point trajectory: coefficients derived once per
// configuration change, then position, velocity and acceleration per query.
// ----------------------------------------------------------------------------
// Takes one query at a time. A query strictly inside the window goes through a
// restoring division for the normalised time and five, four and three Horner
// steps on the shared multiplier (position, velocity, acceleration), and through
// three more divisions by the duration, one for velocity and two for
// acceleration. A query exactly at the start or end time skips the position
// polynomial. A query outside the window, or with a non-positive duration,
// skips the divisions and the Horner steps. The first query after any register
// write first derives the six coefficients: six passes through the shared
// 33x33 multiplier and 36 weighted accumulation steps. The block is ready for
// the next query in the cycle after a result is loaded. A finished result waits
// in the output register while the next query is worked on, and the sequencer
// holds in its last state while that register is still full.
module quintic_trajectory_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qtg_pkg::DATA_W-1:0]       cfg_data,
  qtg_query_if.sink                        query,
  qtg_result_if.source                     result
);
  import qtg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_D_INIT, S_D_V0, S_D_VF, S_D_A0P, S_D_A0, S_D_AFP, S_D_AF,
    S_D_SUM, S_D_STORE, S_M_HI, S_M_LO, S_M_FIN, S_E_START, S_E_S,
    S_V_START, S_H_INIT, S_H_MUL, S_H_ADD, S_P_END, S_V_FIN, S_A_MID,
    S_A_FIN, S_DIV, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_POS, P_VEL, P_ACC} pass_t;
  typedef enum logic [1:0] {MN_ZERO, MN_FRAC, MN_FULL} mshift_t;

  localparam int DCNT_W = $clog2(DIV_W + 1);

  // configuration registers
  logic [DATA_W-1:0]        start_time, end_time;
  logic signed [DATA_W-1:0] start_position, end_position;
  logic signed [DATA_W-1:0] start_velocity, end_velocity;
  logic signed [DATA_W-1:0] start_accel, end_accel;

  // control and datapath registers
  state_t                   state, ret;
  pass_t                    pass;
  mshift_t                  mn;
  logic                     coef_ready;
  logic signed [COEF_W-1:0] coef [NUM_COEF];
  logic signed [COEF_W-1:0] term [NUM_COEF];
  logic [2:0]               ci, cj, k;
  logic signed [ACC_W-1:0]  acc;
  logic [DATA_W-1:0]        qt, durq;
  logic [DATA_W:0]          s, mb;
  logic signed [COEF_W-1:0] mx, mres, h;
  logic [2*DATA_W+1:0]      prod, hi;
  logic [DIV_W-1:0]         dq;
  logic [DATA_W-1:0]        rem;
  logic [DCNT_W-1:0]        dcnt;
  logic                     hneg;
  logic signed [DATA_W-1:0] pos_r, vel_r, acc_r;
  logic [1:0]               phase_r;
  logic                     bad_r;
  logic                     res_valid;
  logic signed [DATA_W-1:0] res_pos, res_vel, res_acc;
  logic [1:0]               res_phase;
  logic                     res_bad;

  // saturate a wide signed value to 64 bits
  function automatic logic signed [COEF_W-1:0] sat64(input logic signed [ACC_W-1:0] x);
    if (x[ACC_W-1:COEF_W-1] == '0 || x[ACC_W-1:COEF_W-1] == '1) return x[COEF_W-1:0];
    return x[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
  endfunction

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [COEF_W-1:0] x);
    if (x[COEF_W-1:DATA_W-1] == '0 || x[COEF_W-1:DATA_W-1] == '1) return x[DATA_W-1:0];
    return x[COEF_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // signed 32-bit result from sign and quotient magnitude, saturated
  function automatic logic signed [DATA_W-1:0] sat32m(input logic neg,
                                                      input logic [DIV_W-1:0] q);
    logic signed [DATA_W:0] v;
    if (|q[DIV_W-1:DATA_W])
      return neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    v = {1'b0, q[DATA_W-1:0]};
    if (neg) v = -v;
    if (v[DATA_W] != v[DATA_W-1])
      return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] mag64(input logic signed [COEF_W-1:0] x);
    return x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
  endfunction

  // derivative scale of coefficient kk in each pass
  function automatic logic signed [5:0] factor(input pass_t p, input logic [2:0] kk);
    logic [5:0] kx;
    kx = {3'b0, kk};
    case (p)
      P_VEL:   return $signed(kx);
      P_ACC:   return $signed(6'(kx * (kx - 6'd1)));
      default: return 6'sd1;
    endcase
  endfunction

  // window decode
  logic [DATA_W-1:0] dur_cfg;
  logic              bad_c, in_win;
  assign bad_c   = end_time <= start_time;
  assign dur_cfg = bad_c ? '0 : end_time - start_time;
  assign in_win  = !bad_c && qt >= start_time && qt <= end_time;

  // shared multiplier, one 32-bit half of the magnitude per cycle
  logic [COEF_W-1:0]   m_mag;
  logic [DATA_W:0]     mul_a;
  logic [2*DATA_W+1:0] mul_p;
  assign m_mag = mag64(mx);
  assign mul_a = (state == S_M_HI) ? {1'b0, m_mag[COEF_W-1:DATA_W]}
                                   : {1'b0, m_mag[DATA_W-1:0]};
  assign mul_p = mul_a * mb;

  // recombination of the partial products, then sign and saturation
  localparam int R_W = 2 * DATA_W + 2 + DATA_W + 1;
  logic [R_W-1:0]           hi_x, lo_x, r_sum;
  logic signed [COEF_W-1:0] m_out;
  always_comb begin
    hi_x = R_W'(hi);
    lo_x = R_W'(prod);
    case (mn)
      MN_ZERO: r_sum = (hi_x << DATA_W) + lo_x;
      MN_FRAC: r_sum = (hi_x << (DATA_W - FRAC_BITS)) + (lo_x >> FRAC_BITS);
      default: r_sum = hi_x + (lo_x >> DATA_W);
    endcase
    if (|r_sum[R_W-1:COEF_W-1])
      m_out = mx[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    else
      m_out = mx[COEF_W-1] ? -$signed(r_sum[COEF_W-1:0]) : $signed(r_sum[COEF_W-1:0]);
  end

  // shared small-constant multiplier
  logic signed [COEF_W-1:0] cm_x;
  logic signed [5:0]        cm_w;
  logic signed [69:0]       cm_p;
  always_comb begin
    if (state == S_D_SUM) begin
      cm_x = term[cj];
      cm_w = WEIGHT[ci][cj];
    end else begin
      cm_x = coef[k];
      cm_w = factor(pass, k);
    end
  end
  assign cm_p = 70'(cm_x) * 70'(cm_w);

  // divider step
  logic [DATA_W:0] d_try;
  logic            d_ge;
  assign d_try = {rem, dq[DIV_W-1]};
  assign d_ge  = d_try >= {1'b0, durq};

  // pass end value of the Horner step
  logic signed [COEF_W-1:0] h_step;
  assign h_step = sat64(ACC_W'(mres) + ACC_W'(sat64(ACC_W'(cm_p))));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      end_time       <= DATA_W'(1) << FRAC_BITS;
      start_position <= '0;
      end_position   <= '0;
      start_velocity <= '0;
      end_velocity   <= '0;
      start_accel    <= '0;
      end_accel      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_TIME:     start_time     <= cfg_data;
        REG_END_TIME:       end_time       <= cfg_data;
        REG_START_POSITION: start_position <= cfg_data;
        REG_END_POSITION:   end_position   <= cfg_data;
        REG_START_VELOCITY: start_velocity <= cfg_data;
        REG_END_VELOCITY:   end_velocity   <= cfg_data;
        REG_START_ACCEL:    start_accel    <= cfg_data;
        REG_END_ACCEL:      end_accel      <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      coef_ready <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (query.valid) begin
            qt    <= query.query_time;
            state <= coef_ready ? S_E_START : S_D_INIT;
          end
        end
        // coefficient derivation
        S_D_INIT: begin
          term[0] <= COEF_W'(start_position) <<< (FRAC_BITS + 1);
          term[1] <= (COEF_W'(end_position) - COEF_W'(start_position)) <<< FRAC_BITS;
          mx    <= COEF_W'(start_velocity);
          mb    <= {1'b0, dur_cfg};
          mn    <= MN_ZERO;
          ret   <= S_D_V0;
          state <= S_M_HI;
        end
        S_D_V0: begin
          term[2] <= mres;
          mx      <= COEF_W'(end_velocity);
          ret     <= S_D_VF;
          state   <= S_M_HI;
        end
        S_D_VF: begin
          term[3] <= mres;
          mx      <= COEF_W'(start_accel);
          ret     <= S_D_A0P;
          state   <= S_M_HI;
        end
        S_D_A0P: begin
          mx    <= mres;
          mn    <= MN_FRAC;
          ret   <= S_D_A0;
          state <= S_M_HI;
        end
        S_D_A0: begin
          term[4] <= mres;
          mx      <= COEF_W'(end_accel);
          mn      <= MN_ZERO;
          ret     <= S_D_AFP;
          state   <= S_M_HI;
        end
        S_D_AFP: begin
          mx    <= mres;
          mn    <= MN_FRAC;
          ret   <= S_D_AF;
          state <= S_M_HI;
        end
        S_D_AF: begin
          term[5] <= mres;
          ci      <= '0;
          cj      <= '0;
          acc     <= '0;
          state   <= S_D_SUM;
        end
        S_D_SUM: begin
          acc <= acc + ACC_W'(cm_p);
          if (cj == 3'(NUM_COEF - 1)) state <= S_D_STORE;
          else cj <= cj + 3'd1;
        end
        S_D_STORE: begin
          coef[ci] <= sat64(acc >>> COEFF_SHIFT);
          acc      <= '0;
          cj       <= '0;
          if (ci == 3'(NUM_COEF - 1)) begin
            state <= S_E_START;
          end else begin
            ci    <= ci + 3'd1;
            state <= S_D_SUM;
          end
        end
        // shared multiply with truncating rescale
        S_M_HI: begin
          prod  <= mul_p;
          state <= S_M_LO;
        end
        S_M_LO: begin
          hi    <= prod;
          prod  <= mul_p;
          state <= S_M_FIN;
        end
        S_M_FIN: begin
          mres  <= m_out;
          state <= ret;
        end
        // evaluation: normalised time
        S_E_START: begin
          bad_r   <= bad_c;
          phase_r <= (qt < start_time) ? PHASE_BEFORE
                   : (qt > end_time) ? PHASE_AFTER : PHASE_WINDOW;
          durq    <= in_win ? dur_cfg : '0;
          if (in_win) begin
            dq    <= DIV_W'({qt - start_time, {DATA_W{1'b0}}});
            rem   <= '0;
            dcnt  <= DCNT_W'(DIV_W);
            ret   <= S_E_S;
            state <= S_DIV;
          end else begin
            state <= S_E_S;
          end
        end
        S_E_S: begin
          s <= (durq != '0) ? dq[DATA_W:0] : '0;
          k <= 3'(NUM_COEF - 1);
          if (qt <= start_time) begin
            pos_r <= start_position;
            state <= S_V_START;
          end else if (qt >= end_time) begin
            pos_r <= end_position;
            state <= S_V_START;
          end else begin
            pass  <= P_POS;
            state <= S_H_INIT;
          end
        end
        S_V_START: begin
          k <= 3'(NUM_COEF - 1);
          if (durq != '0) begin
            pass  <= P_VEL;
            state <= S_H_INIT;
          end else begin
            vel_r <= '0;
            acc_r <= '0;
            state <= S_DONE;
          end
        end
        // Horner loop
        S_H_INIT: begin
          h     <= sat64(ACC_W'(cm_p));
          k     <= k - 3'd1;
          state <= S_H_MUL;
        end
        S_H_MUL: begin
          mx    <= h;
          mb    <= s;
          mn    <= MN_FULL;
          ret   <= S_H_ADD;
          state <= S_M_HI;
        end
        S_H_ADD: begin
          h <= h_step;
          if ((pass == P_POS && k == 3'd0) || (pass == P_VEL && k == 3'd1) ||
              (pass == P_ACC && k == 3'd2)) begin
            state <= S_P_END;
          end else begin
            k     <= k - 3'd1;
            state <= S_H_MUL;
          end
        end
        S_P_END: begin
          hneg <= h[COEF_W-1];
          dq   <= DIV_W'(mag64(h));
          rem  <= '0;
          dcnt <= DCNT_W'(DIV_W);
          case (pass)
            P_POS: begin
              pos_r <= sat32(h >>> (COEFF_FRAC_BITS - FRAC_BITS));
              state <= S_V_START;
            end
            P_VEL: begin
              ret   <= S_V_FIN;
              state <= S_DIV;
            end
            default: begin
              ret   <= S_A_MID;
              state <= S_DIV;
            end
          endcase
        end
        S_V_FIN: begin
          vel_r <= sat32m(hneg, dq);
          pass  <= P_ACC;
          k     <= 3'(NUM_COEF - 1);
          state <= S_H_INIT;
        end
        S_A_MID: begin
          dq    <= {dq[COEF_W-1:0], {FRAC_BITS{1'b0}}};
          rem   <= '0;
          dcnt  <= DCNT_W'(DIV_W);
          ret   <= S_A_FIN;
          state <= S_DIV;
        end
        S_A_FIN: begin
          acc_r <= sat32m(hneg, dq);
          state <= S_DONE;
        end
        // restoring divider, one quotient bit per cycle
        S_DIV: begin
          rem  <= d_ge ? DATA_W'(d_try - {1'b0, durq}) : d_try[DATA_W-1:0];
          dq   <= {dq[DIV_W-2:0], d_ge};
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == DCNT_W'(1)) state <= ret;
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_pos   <= pos_r;
            res_vel   <= vel_r;
            res_acc   <= acc_r;
            res_phase <= phase_r;
            res_bad   <= bad_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // any register write invalidates the coefficients
      if (cfg_we) coef_ready <= 1'b0;
      else if (state == S_D_STORE && ci == 3'(NUM_COEF - 1)) coef_ready <= 1'b1;
    end
  end

  // channel outputs
  assign query.ready         = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.position     = res_pos;
  assign result.velocity     = res_vel;
  assign result.acceleration = res_acc;
  assign result.phase        = res_phase;
  assign result.bad_duration = res_bad;

`ifndef NO_ASSERTIONS
  // degenerate duration never yields motion
  a_bad_still: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_duration |-> result.velocity == 0 && result.acceleration == 0)
    else $error("motion reported with bad duration");

  // outside the window velocity and acceleration are zero
  a_out_still: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.phase != PHASE_WINDOW |->
      result.velocity == 0 && result.acceleration == 0)
    else $error("motion reported outside window");

  // divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> durq != '0)
    else $error("division by zero duration");

  // an accepted query always leaves idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> !query.ready)
    else $error("query accepted while staying idle");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quintic trajectory generator. Queries are fed
// from a queue through a clocked driver with random idling; every accepted
// query is evaluated by a local bit-exact fixed-point predictor. A clocked
// monitor stalls the result channel at random and compares every result
// transaction field by field with the oldest expected trajectory point.
// ----------------------------------------------------------------------------
module tb_top;
  import qtg_pkg::*;

  localparam int           WATCHDOG_LIMIT = 20000;
  localparam longint       S64_MAX = 64'sh7fffffffffffffff;
  localparam longint       S64_MIN = 64'sh8000000000000000;
  localparam logic [127:0] MAG_TOP = 128'h1 << 63;

  typedef struct {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [1:0]         phase;
    logic               bad_duration;
  } traj_point_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  qtg_query_if  q_if ();
  qtg_result_if r_if ();

  quintic_trajectory_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (q_if),
    .result    (r_if)
  );

  always #10 clk = ~clk;

  // predictor state: shadow registers and derived coefficients
  logic [31:0]        traj_reg [8];
  logic signed [63:0] coef [6];
  bit                 coef_valid;

  // doubled coefficient weights over {2p0, h, v0T, vfT, a0T^2, afT^2}
  int coef_weight [6][6] = '{
    '{1,   0,   0,  0,  0,  0},
    '{0,   0,   2,  0,  0,  0},
    '{0,   0,   0,  0,  1,  0},
    '{0,  20, -12, -8, -3,  1},
    '{0, -30,  16, 14,  3, -2},
    '{0,  12,  -6, -6, -1,  1}
  };

  logic [31:0]  pending_times [$];
  traj_point_t  expected_points [$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           recv_hold_cycles = 0;
  int           error_count = 0;
  int           quiet_cycles = 0;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint signed_from_mag(bit neg, logic [127:0] m);
    if (neg) return m >= MAG_TOP ? S64_MIN : -longint'(m[63:0]);
    return m >= MAG_TOP ? S64_MAX : longint'(m[63:0]);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return longint'(s[63:0]);
  endfunction

  function automatic longint scale_sat(longint a, int k);
    longint r;
    r = 0;
    for (int i = 0; i < k; i++) r = add_sat(r, a);
    return r;
  endfunction

  // trunc(a * b / 2^n), saturated
  function automatic longint mul_shift(longint a, logic [63:0] b, int n);
    logic [127:0] p;
    p = {64'b0, magnitude(a)} * {64'b0, b};
    return signed_from_mag(a < 0, p >> n);
  endfunction

  // trunc(x * 2^k / t), saturated
  function automatic longint div_time(longint x, int k, logic [63:0] t);
    logic [127:0] m;
    m = {64'b0, magnitude(x)} << k;
    return signed_from_mag(x < 0, m / {64'b0, t});
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sh7fffffff) return 32'sh7fffffff;
    if (x < -64'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

  // --------------------------------------------------------------- predictor
  function automatic void derive_coefficients();
    logic [63:0]         st, en, dur;
    longint              p0, pf, v0, vf, a0, af;
    longint              term [6];
    logic signed [127:0] acc, tt;
    st = traj_reg[REG_START_TIME];
    en = traj_reg[REG_END_TIME];
    dur = en > st ? en - st : 64'd0;
    p0 = longint'($signed(traj_reg[REG_START_POSITION]));
    pf = longint'($signed(traj_reg[REG_END_POSITION]));
    v0 = longint'($signed(traj_reg[REG_START_VELOCITY]));
    vf = longint'($signed(traj_reg[REG_END_VELOCITY]));
    a0 = longint'($signed(traj_reg[REG_START_ACCEL]));
    af = longint'($signed(traj_reg[REG_END_ACCEL]));
    term[0] = p0 * (64'sd1 <<< (FRAC_BITS + 1));
    term[1] = (pf - p0) * (64'sd1 <<< FRAC_BITS);
    term[2] = v0 * longint'(dur);
    term[3] = vf * longint'(dur);
    term[4] = mul_shift(a0 * longint'(dur), dur, FRAC_BITS);
    term[5] = mul_shift(af * longint'(dur), dur, FRAC_BITS);
    for (int i = 0; i < 6; i++) begin
      acc = '0;
      for (int j = 0; j < 6; j++) begin
        tt = term[j];
        acc = acc + tt * coef_weight[i][j];
      end
      // undo the doubling with floor, then saturate
      acc = acc >>> 1;
      if (acc > S64_MAX) coef[i] = S64_MAX;
      else if (acc < S64_MIN) coef[i] = S64_MIN;
      else coef[i] = acc[63:0];
    end
    coef_valid = 1'b1;
  endfunction

  function automatic traj_point_t trajectory_at(logic [31:0] t);
    traj_point_t pt;
    logic [31:0] st, en;
    logic [63:0] dur, s, diff;
    longint      h;
    st = traj_reg[REG_START_TIME];
    en = traj_reg[REG_END_TIME];
    if (!coef_valid) derive_coefficients();
    pt.bad_duration = en <= st;
    pt.phase = t < st ? PHASE_BEFORE : (t > en ? PHASE_AFTER : PHASE_WINDOW);
    dur = 0;
    s = 0;
    if (!pt.bad_duration && t >= st && t <= en) begin
      dur = 64'(en) - 64'(st);
      diff = 64'(t) - 64'(st);
      s = (diff << 32) / dur;
    end
    // position clamps to the end points outside the open window
    if (t <= st) pt.position = traj_reg[REG_START_POSITION];
    else if (t >= en) pt.position = traj_reg[REG_END_POSITION];
    else begin
      h = coef[5];
      for (int k = 4; k >= 0; k--) h = add_sat(mul_shift(h, s, 32), coef[k]);
      pt.position = clamp32(h >>> (COEFF_FRAC_BITS - FRAC_BITS));
    end
    pt.velocity = '0;
    pt.acceleration = '0;
    if (dur != 0) begin
      h = scale_sat(coef[5], 5);
      for (int k = 4; k >= 1; k--)
        h = add_sat(mul_shift(h, s, 32), scale_sat(coef[k], k));
      pt.velocity = clamp32(div_time(h, 2 * FRAC_BITS - COEFF_FRAC_BITS, dur));
      h = scale_sat(coef[5], 20);
      for (int k = 4; k >= 2; k--)
        h = add_sat(mul_shift(h, s, 32), scale_sat(coef[k], k * (k - 1)));
      pt.acceleration = clamp32(div_time(div_time(h, 2 * FRAC_BITS - COEFF_FRAC_BITS,
                                                  dur), FRAC_BITS, dur));
    end
    return pt;
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (rst) begin
      q_if.valid <= 1'b0;
      q_if.query_time <= '0;
    end else begin
      if (q_if.valid && q_if.ready) expected_points.push_back(trajectory_at(q_if.query_time));
      if (!q_if.valid || q_if.ready) begin
        if (pending_times.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          q_if.valid <= 1'b1;
          q_if.query_time <= pending_times.pop_front();
        end else begin
          q_if.valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    traj_point_t want;
    if (rst) begin
      r_if.ready <= 1'b0;
    end else begin
      if (r_if.valid && r_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result transaction");
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (r_if.position !== want.position) begin
            $error("position: expected %h, got %h", want.position, r_if.position);
            error_count++;
          end
          if (r_if.velocity !== want.velocity) begin
            $error("velocity: expected %h, got %h", want.velocity, r_if.velocity);
            error_count++;
          end
          if (r_if.acceleration !== want.acceleration) begin
            $error("acceleration: expected %h, got %h", want.acceleration,
                   r_if.acceleration);
            error_count++;
          end
          if (r_if.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, r_if.phase);
            error_count++;
          end
          if (r_if.bad_duration !== want.bad_duration) begin
            $error("bad_duration: expected %0d, got %0d", want.bad_duration,
                   r_if.bad_duration);
            error_count++;
          end
        end
      end
      // long hold-off lets the block fill up and stall its input
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        r_if.ready <= 1'b0;
      end else begin
        r_if.ready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    traj_reg[idx] = val;
    coef_valid = 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_times.size() > 0 || q_if.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_profile(logic [31:0] st, logic [31:0] en, logic [31:0] p0,
                              logic [31:0] pf, logic [31:0] v0, logic [31:0] vf,
                              logic [31:0] a0, logic [31:0] af);
    wait_drained();
    write_reg(REG_START_TIME, st);
    write_reg(REG_END_TIME, en);
    write_reg(REG_START_POSITION, p0);
    write_reg(REG_END_POSITION, pf);
    write_reg(REG_START_VELOCITY, v0);
    write_reg(REG_END_VELOCITY, vf);
    write_reg(REG_START_ACCEL, a0);
    write_reg(REG_END_ACCEL, af);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(0, 32'h100000)) - 32'sh80000);
    endcase
  endfunction

  task automatic random_profile();
    logic [63:0] st, en;
    st = $urandom_range(3) == 0 ? 64'($urandom) : 64'($urandom_range(0, 32'h80000));
    case ($urandom_range(9))
      0:       en = st > 0 ? st - $urandom_range(0, 32'(st)) : 0;
      1:       en = st + $urandom_range(1, 16);
      2:       en = st + $urandom;
      default: en = st + $urandom_range(32'h1000, 32'h80000);
    endcase
    if (en > 64'hffffffff) en = 64'hffffffff;
    load_profile(st[31:0], en[31:0], rand_value(), rand_value(), rand_value(),
                 rand_value(), rand_value(), rand_value());
  endtask

  function automatic logic [31:0] rand_query();
    logic [63:0] st, en;
    st = traj_reg[REG_START_TIME];
    en = traj_reg[REG_END_TIME];
    if (en <= st || $urandom_range(99) < 15) return $urandom;
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0:       return st[31:0];
        1:       return en[31:0];
        2:       return st[31:0] - 1;
        default: return en[31:0] + 1;
      endcase
    end
    return 32'(st + {$urandom, $urandom} % (en - st + 1));
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) traj_reg[i] = '0;
    traj_reg[REG_END_TIME] = 32'h10000;
    coef_valid = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset profile: everything at rest
    pending_times = '{32'h0, 32'h1, 32'h8000, 32'h10000, 32'h10001, 32'hffffffff};

    // extremes over the widest window
    load_profile(32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h7fffffff);
    pending_times = '{32'h0, 32'h1, 32'h80000000, 32'hfffffffe, 32'hffffffff};

    // zero duration, then end before start
    load_profile(32'h20000, 32'h20000, 32'h12345, 32'hfffe0000, 32'h10000,
                 32'h10000, 32'h10000, 32'h10000);
    pending_times = '{32'h1ffff, 32'h20000, 32'h20001};
    load_profile(32'h50000, 32'h20000, 32'h30000, 32'h70000, 32'h0, 32'h0,
                 32'h0, 32'h0);
    pending_times = '{32'h10000, 32'h30000, 32'h60000};

    // shortest window with large rates, results saturate
    load_profile(32'h10000, 32'h10001, 32'h0, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000);
    pending_times = '{32'h10000, 32'h10001, 32'hffff, 32'h10002};

    // ordinary point-to-point move; receiver holds off while queries pile up
    load_profile(32'h10000, 32'h30000, 32'hfffe0000, 32'h50000, 32'h8000,
                 32'hffff0000, 32'h4000, 32'h20000);
    recv_hold_cycles = 2000;
    for (int i = 0; i < 4; i++) pending_times.push_back(32'h10000 + i * 32'h8000);

    // random profiles under the four idling patterns
    for (int p = 0; p < 4; p++) begin
      for (int blk = 0; blk < 5; blk++) begin
        random_profile();
        case (p)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
          default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
        for (int i = 0; i < 30; i++) pending_times.push_back(rand_query());
      end
    end

    wait_drained();
    repeat (500) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/qtg_pkg.sv
rtl/qtg_query_if.sv
rtl/qtg_result_if.sv
rtl/quintic_trajectory_generator_core.sv
test/tb_top.sv
